// ===== design/r2q_pkg.sv =====
`timescale 1ns / 1ps
package r2q_pkg;

  // Field and datapath widths.
  localparam int FW = 18;   // matrix entries and quaternion outputs
  localparam int CW = 21;   // candidates and numerators, signed
  localparam int RW = 26;   // square root, units of 2^-24
  localparam int NW = 2 * RW; // radicand, candidate times 2^32
  localparam int DW = 45;   // dividend and partial remainder
  localparam int QW = 18;   // quotient bits kept before saturation
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic signed [CW-1:0] ONE_FX = CW'(65536);
  localparam logic signed [FW-1:0] OUT_MAX = FW'(131071);
  localparam logic signed [FW-1:0] OUT_MIN = FW'(-131072);
  localparam logic [QW-1:0] NEG_LIMIT = QW'(131072);

  typedef logic signed [FW-1:0] fx_t;
  typedef logic signed [CW-1:0] cand_t;

  typedef enum logic [1:0] {
    PIV_TRACE = 2'd0,
    PIV_D1    = 2'd1,
    PIV_D2    = 2'd2,
    PIV_D3    = 2'd3
  } pivot_t;

  // One classified matrix, as it waits in the queue.
  typedef struct packed {
    logic             bad;
    pivot_t           pivot;
    cand_t            best;
    logic [3:0][CW-1:0] num;
  } job_t;

  // Result of the square root, handed to the dividers.
  typedef struct packed {
    logic          vld;
    logic [RW-1:0] root;
    job_t          job;
  } root_t;

endpackage

// ===== design/r2q_if.sv =====
`timescale 1ns / 1ps
interface r2q_mat_if;
  import r2q_pkg::*;
  logic valid;
  logic ready;
  fx_t m11, m12, m13, m21, m22, m23, m31, m32, m33;
  modport source(output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, input ready);
  modport sink(input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, output ready);
endinterface

interface r2q_quat_if;
  import r2q_pkg::*;
  logic valid;
  logic ready;
  fx_t q_scalar, q_x, q_y, q_z;
  logic [1:0] pivot_case;
  logic bad_matrix;
  modport source(output valid, q_scalar, q_x, q_y, q_z, pivot_case, bad_matrix, input ready);
  modport sink(input valid, q_scalar, q_x, q_y, q_z, pivot_case, bad_matrix, output ready);
endinterface

// ===== design/r2q_front.sv =====
`timescale 1ns / 1ps
module r2q_front (
  input  r2q_pkg::fx_t m11,
  input  r2q_pkg::fx_t m12,
  input  r2q_pkg::fx_t m13,
  input  r2q_pkg::fx_t m21,
  input  r2q_pkg::fx_t m22,
  input  r2q_pkg::fx_t m23,
  input  r2q_pkg::fx_t m31,
  input  r2q_pkg::fx_t m32,
  input  r2q_pkg::fx_t m33,
  output r2q_pkg::job_t job
);
  import r2q_pkg::*;

  function automatic logic [CW-1:0] mag_of(cand_t c);
    return c[CW-1] ? CW'(-c) : CW'(c);
  endfunction

  cand_t tr;
  cand_t cand [4];
  logic [CW-1:0] mag [4];
  cand_t d1, d2, d3, s12, s13, s23;
  cand_t best;
  logic [1:0] k;

  // The four candidates of Shepperd's method.
  always_comb begin
    tr = CW'(m11) + CW'(m22) + CW'(m33);
    cand[0] = ONE_FX + tr;
    cand[1] = ONE_FX - tr + (CW'(m11) <<< 1);
    cand[2] = ONE_FX - tr + (CW'(m22) <<< 1);
    cand[3] = ONE_FX - tr + (CW'(m33) <<< 1);
    for (int i = 0; i < 4; i++) begin
      mag[i] = mag_of(cand[i]);
    end
  end

  // Largest magnitude wins; a tie goes to the later candidate.
  always_comb begin
    k = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (mag[i] >= mag[k]) begin
        k = 2'(i);
      end
    end
    best = cand[k];
  end

  // Off-diagonal sums and differences, placed by case.
  always_comb begin
    d1  = CW'(m32) - CW'(m23);
    d2  = CW'(m13) - CW'(m31);
    d3  = CW'(m21) - CW'(m12);
    s12 = CW'(m12) + CW'(m21);
    s13 = CW'(m13) + CW'(m31);
    s23 = CW'(m23) + CW'(m32);
    job.best  = best;
    job.pivot = pivot_t'(k);
    job.bad   = best[CW-1] || (best == '0);
    unique case (job.pivot)
      PIV_TRACE: job.num = {d3, d2, d1, best};
      PIV_D1:    job.num = {s13, s12, best, d1};
      PIV_D2:    job.num = {s23, best, s12, d2};
      PIV_D3:    job.num = {best, s23, s13, d3};
      default:   job.num = '0;
    endcase
  end

endmodule

// ===== design/r2q_queue.sv =====
`timescale 1ns / 1ps
module r2q_queue #(
  parameter int DEPTH = r2q_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  r2q_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output r2q_pkg::job_t rdata,
  output logic          empty
);
  import r2q_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CNW-1:0] count;

  assign full  = (count == CNW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // Storage is written on every push; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/r2q_sqrt.sv =====
`timescale 1ns / 1ps
module r2q_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  r2q_pkg::job_t  in_job,
  output r2q_pkg::root_t out
);
  import r2q_pkg::*;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [RW-1:0] res;
    job_t          job;
  } sq_stage_t;

  logic      vld [RW+1];
  sq_stage_t st  [RW+1];

  // Radicand is the picked candidate times 2^32; zero for a bad matrix.
  always_comb begin
    vld[0]    = in_vld;
    st[0].job = in_job;
    st[0].res = '0;
    st[0].rem = in_job.bad ? '0 : (NW'(in_job.best[CW-2:0]) << 32);
  end

  // One root bit per stage, most significant first.
  for (genvar s = 0; s < RW; s++) begin : g_step
    localparam int B = RW - 1 - s;
    logic [NW-1:0] trial;
    assign trial = (NW'(st[s].res) << (B + 1)) | (NW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s+1].job <= st[s].job;
        if (st[s].rem >= trial) begin
          st[s+1].rem <= st[s].rem - trial;
          st[s+1].res <= st[s].res | (RW'(1) << B);
        end else begin
          st[s+1].rem <= st[s].rem;
          st[s+1].res <= st[s].res;
        end
      end
    end
  end

  assign out.vld  = vld[RW];
  assign out.root = st[RW].res;
  assign out.job  = st[RW].job;

endmodule

// ===== design/r2q_div.sv =====
`timescale 1ns / 1ps
module r2q_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  r2q_pkg::root_t in,
  output logic           out_vld,
  output r2q_pkg::fx_t   q_scalar,
  output r2q_pkg::fx_t   q_x,
  output r2q_pkg::fx_t   q_y,
  output r2q_pkg::fx_t   q_z,
  output logic [1:0]     pivot_case,
  output logic           bad_matrix
);
  import r2q_pkg::*;

  typedef struct packed {
    logic [3:0][DW-1:0] rem;
    logic [3:0][QW-1:0] quo;
    logic [3:0]         neg;
    logic [3:0]         ovf;
    logic [QW-1:0]      scalar;
    logic [RW:0]        dsr;
    logic               bad;
    pivot_t             pivot;
  } dv_stage_t;

  function automatic fx_t sat_q(logic neg, logic ovf, logic [QW-1:0] q);
    if (!neg) begin
      return (ovf || q[QW-1]) ? OUT_MAX : fx_t'(q);
    end
    return (ovf || (q > NEG_LIMIT)) ? OUT_MIN : fx_t'(-q);
  endfunction

  logic      vld [QW+1];
  dv_stage_t st  [QW+1];

  logic [RW:0]        dsr_in;
  logic [RW:0]        rnd;
  dv_stage_t          prep;
  logic [CW-1:0]      mag [4];

  // Dividends, divisor, overflow test and the scalar from the root.
  always_comb begin
    dsr_in = {in.root, 1'b0};
    rnd    = (RW+1)'(in.root) + (RW+1)'(256);
    prep.dsr    = dsr_in;
    prep.bad    = in.job.bad;
    prep.pivot  = in.job.pivot;
    prep.scalar = rnd[RW:9];
    prep.quo    = '0;
    for (int j = 0; j < 4; j++) begin
      prep.neg[j] = in.job.num[j][CW-1];
      mag[j] = prep.neg[j] ? CW'(-in.job.num[j]) : in.job.num[j];
      prep.rem[j] = (DW'(mag[j]) << 24) + DW'(in.root);
      prep.ovf[j] = prep.rem[j] >= (DW'(dsr_in) << QW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= prep;
    end
  end

  // Restoring division, one quotient bit per stage for all four lanes.
  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int B = QW - 1 - s;
    logic [DW-1:0] sub;
    dv_stage_t nxt;
    assign sub = DW'(st[s].dsr) << B;

    always_comb begin
      nxt = st[s];
      for (int j = 0; j < 4; j++) begin
        if (st[s].rem[j] >= sub) begin
          nxt.rem[j] = st[s].rem[j] - sub;
          nxt.quo[j] = st[s].quo[j] | (QW'(1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s+1] <= nxt;
      end
    end
  end

  // Output register: saturation, scalar in the trace case, bad matrix zeroing.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st[QW].bad) begin
        q_scalar   <= '0;
        q_x        <= '0;
        q_y        <= '0;
        q_z        <= '0;
        pivot_case <= PIV_TRACE;
        bad_matrix <= 1'b1;
      end else begin
        if (st[QW].pivot == PIV_TRACE) begin
          q_scalar <= st[QW].scalar[QW-1] ? OUT_MAX : fx_t'(st[QW].scalar);
        end else begin
          q_scalar <= sat_q(st[QW].neg[0], st[QW].ovf[0], st[QW].quo[0]);
        end
        q_x        <= sat_q(st[QW].neg[1], st[QW].ovf[1], st[QW].quo[1]);
        q_y        <= sat_q(st[QW].neg[2], st[QW].ovf[2], st[QW].quo[2]);
        q_z        <= sat_q(st[QW].neg[3], st[QW].ovf[3], st[QW].quo[3]);
        pivot_case <= st[QW].pivot;
        bad_matrix <= 1'b0;
      end
    end
  end

endmodule

// ===== design/rotation_to_quaternion.sv =====
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion, Shepperd's method.
// A matrix (nine S1.16 entries) enters on matrix_in with valid/ready; each
// transaction gives exactly one result on quat_out: the four Euler parameters
// in S1.16, the picked case and a bad-matrix flag (all other fields zero).
// The front classifies the matrix in the cycle of its transaction and writes
// it into a small queue. The back pops the queue into a 26-stage square-root
// pipeline (one root bit a stage), one set-up stage, an 18-stage divider
// (one quotient bit a stage, four lanes) and the output register.
// Throughput is one matrix per cycle while the receiver keeps ready high.
// When the receiver holds ready low with a result waiting, the whole back
// pipeline holds; the queue keeps taking matrices until it is full, and only
// then does matrix_in.ready fall.
// Reset clears the queue and every stage valid; no result is left pending.
module rotation_to_quaternion #(
  parameter int QUEUE_DEPTH = r2q_pkg::QUEUE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  r2q_mat_if.sink    matrix_in,
  r2q_quat_if.source quat_out
);
  import r2q_pkg::*;

  job_t  front_job;
  job_t  queue_job;
  root_t root;
  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  logic  adv;

  // The back pipeline moves when the output register is free or being taken.
  assign adv  = !quat_out.valid || quat_out.ready;
  assign matrix_in.ready = !q_full;
  assign push = matrix_in.valid && !q_full;
  assign pop  = adv && !q_empty;

  r2q_front u_front (
    .m11(matrix_in.m11), .m12(matrix_in.m12), .m13(matrix_in.m13),
    .m21(matrix_in.m21), .m22(matrix_in.m22), .m23(matrix_in.m23),
    .m31(matrix_in.m31), .m32(matrix_in.m32), .m33(matrix_in.m33),
    .job(front_job)
  );

  r2q_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .wdata(front_job), .full(q_full),
    .pop(pop), .rdata(queue_job), .empty(q_empty)
  );

  r2q_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(pop), .in_job(queue_job), .out(root)
  );

  r2q_div u_div (
    .clk(clk), .rst(rst), .en(adv), .in(root),
    .out_vld(quat_out.valid),
    .q_scalar(quat_out.q_scalar), .q_x(quat_out.q_x),
    .q_y(quat_out.q_y), .q_z(quat_out.q_z),
    .pivot_case(quat_out.pivot_case), .bad_matrix(quat_out.bad_matrix)
  );

endmodule
